// ----- sv/double_hash_table_top_macros.svh -----
// ----------------------------------------------------------------------------
// Double hash table assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_TOP_MACROS_SVH
`define DOUBLE_HASH_TABLE_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define DHT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("double hash table assertion failed");

// Check the consequent in the cycle after the antecedent.
`define DHT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("double hash table assertion failed");

`endif

// ----- sv/dht_pkg.sv -----
// ----------------------------------------------------------------------------
// Double hash table package
// Codes, fixed widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dht_pkg;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdSearch = 2'd1,
    CmdDelete = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ResInserted = 3'd0,
    ResFound    = 3'd1,
    ResMissing  = 3'd2,
    ResDeleted  = 3'd3,
    ResFull     = 3'd4
  } res_e;

  typedef enum logic [1:0] {
    SlotEmpty = 2'd0,
    SlotUsed  = 2'd1,
    SlotGone  = 2'd2
  } slot_e;

  localparam int unsigned KeyW        = 15;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned OccW        = 4;
  localparam int unsigned HomeMod     = 11;
  localparam int unsigned HomeBias    = 7;
  localparam int unsigned BiasW       = 16;
  localparam int unsigned SqW         = 32;
  localparam int unsigned RevW        = 17;
  localparam int unsigned DivTenMul   = 52429;
  localparam int unsigned DivTenShift = 19;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned RedW        = 32;
  localparam int unsigned NibW        = 4;
  localparam int unsigned HomeNibbles = 8;
  localparam int unsigned StepNibbles = 5;

  typedef struct packed {
    logic load;
    logic sq_en;
    logic red_load_home;
    logic red_load_step;
    logic red_run;
    logic red_slots;
    logic probe_prime;
    logic probe_run;
    logic wr_ins;
    logic wr_del;
    logic res_set;
    res_e res_code;
    logic res_hit;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic rd_empty;
    logic rd_used;
    logic key_match;
    logic last_probe;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- sv/dht_datapath.sv -----
// ----------------------------------------------------------------------------
// Double hash table datapath
// Hash units, shared modulo reducer, slot store, probe address and output word.
// ----------------------------------------------------------------------------
module dht_datapath #(
  parameter int unsigned TABLE_SLOTS = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             command_i,
  input  logic [14:0]            key_i,
  input  dht_pkg::dp_cmd_t       cmd_i,
  output dht_pkg::dp_sts_t       sts_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [2:0]             status_o,
  output logic [3:0]             slot_o,
  output logic [3:0]             occupancy_o
);
  import dht_pkg::*;

  localparam int unsigned SW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned RW = SW + 1;

  cmd_e               cmd_q;
  logic [KeyW-1:0]    key_q;

  // digit reversal
  logic [KeyW-1:0]    dig_k_q;
  logic [RevW-1:0]    rev_q;
  logic [31:0]        dig_prod;
  logic [KeyW-1:0]    dig_quo;
  logic [KeyW-1:0]    quo_x10;
  logic [DigitW-1:0]  dig_rem;
  logic [RevW-1:0]    rev_next;

  // home hash
  logic [BiasW-1:0]   key_bias;
  logic [SqW-1:0]     sq_q;
  logic [RedW-1:0]    home_sum;

  // modulo reducer
  logic [RedW-1:0]    sh_q;
  logic [RW-1:0]      red_q;
  logic [RW-1:0]      red_mod;
  logic [RW-1:0]      red_acc;
  logic [RW-1:0]      red_try;
  logic [RW-1:0]      red_next;

  // probing
  logic [SW-1:0]      step_q;
  logic [SW-1:0]      pos_q;
  logic [SW-1:0]      pidx_q;
  logic [SW-1:0]      rd_pos_q;
  logic [SW-1:0]      step_use;
  logic [SW:0]        pos_sum;
  logic [SW-1:0]      pos_adv;
  logic               rd_en;

  // slot store
  logic [KeyW-1:0]    key_mem [TABLE_SLOTS];
  slot_e              stat_q  [TABLE_SLOTS];
  logic [KeyW-1:0]    key_rd_q;
  slot_e              stat_rd_q;
  logic [CW-1:0]      count_q;

  // result and output word
  res_e               res_status_q;
  logic [SW-1:0]      res_slot_q;
  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [SlotW-1:0]   slot_q;
  logic [OccW-1:0]    occ_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= key_i;
    end
  end

  // One decimal digit per cycle; the loop stops by itself when the rest is zero.
  assign dig_prod = 32'(dig_k_q) * 32'(DivTenMul);
  assign dig_quo  = KeyW'(dig_prod >> DivTenShift);
  assign quo_x10  = KeyW'({dig_quo, 3'b000} + {2'b00, dig_quo, 1'b0});
  assign dig_rem  = DigitW'(dig_k_q - quo_x10);
  assign rev_next = RevW'({rev_q, 3'b000} + {2'b00, rev_q, 1'b0} + (RevW + 3)'(dig_rem));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dig_k_q <= key_i;
      rev_q   <= '0;
    end else if (dig_k_q != '0) begin
      dig_k_q <= dig_quo;
      rev_q   <= rev_next;
    end
  end

  assign key_bias = BiasW'(key_q) + BiasW'(HomeBias);
  assign home_sum = RedW'(sq_q >> 4) + RedW'(key_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sq_q <= SqW'(key_bias) * SqW'(key_bias);
    end
  end

  // Remainder by restoring steps, one nibble per cycle from the top.
  always_comb begin
    red_mod = cmd_i.red_slots ? RW'(TABLE_SLOTS) : RW'(HomeMod);
    red_acc = red_q;
    red_try = red_q;
    for (int j = 0; j < NibW; j++) begin
      red_try = {red_acc[RW-2:0], sh_q[RedW-1-j]};
      if (red_try >= red_mod) begin
        red_try = red_try - red_mod;
      end
      red_acc = red_try;
    end
    red_next = red_acc;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.red_load_home) begin
      sh_q  <= home_sum;
      red_q <= '0;
    end else if (cmd_i.red_load_step) begin
      sh_q  <= RedW'(rev_q) << (RedW - StepNibbles * NibW);
      red_q <= '0;
    end else if (cmd_i.red_run) begin
      sh_q  <= sh_q << NibW;
      red_q <= red_next;
    end
  end

  // The reducer holds the step on the prime cycle, the step register after.
  assign step_use = cmd_i.probe_prime ? red_q[SW-1:0] : step_q;
  assign pos_sum  = (SW + 1)'(pos_q) + (SW + 1)'(step_use);
  assign pos_adv  = (pos_sum >= (SW + 1)'(TABLE_SLOTS)) ?
                    SW'(pos_sum - (SW + 1)'(TABLE_SLOTS)) : SW'(pos_sum);
  assign rd_en    = cmd_i.probe_prime | cmd_i.probe_run;

  always_ff @(posedge clk_i) begin
    if (cmd_i.red_load_step) begin
      pos_q <= red_q[SW-1:0];
    end else if (rd_en) begin
      pos_q <= pos_adv;
    end
    if (cmd_i.probe_prime) begin
      step_q <= red_q[SW-1:0];
      pidx_q <= '0;
    end else if (cmd_i.probe_run) begin
      pidx_q <= pidx_q + SW'(1);
    end
    if (rd_en) begin
      rd_pos_q  <= pos_q;
      stat_rd_q <= stat_q[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_ins) begin
      key_mem[rd_pos_q] <= key_q;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        stat_q[i] <= SlotEmpty;
      end
      count_q <= '0;
    end else if (cmd_i.wr_ins) begin
      stat_q[rd_pos_q] <= SlotUsed;
      count_q          <= count_q + CW'(1);
    end else if (cmd_i.wr_del) begin
      stat_q[rd_pos_q] <= SlotGone;
      count_q          <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_slot_q   <= cmd_i.res_hit ? rd_pos_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= StatusW'(res_status_q);
      slot_q   <= res_slot_q[SlotW-1:0];
      occ_q    <= count_q[OccW-1:0];
    end
  end

  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.full       = (count_q == CW'(TABLE_SLOTS));
    sts_o.rd_empty   = (stat_rd_q == SlotEmpty);
    sts_o.rd_used    = (stat_rd_q == SlotUsed);
    sts_o.key_match  = (key_rd_q == key_q);
    sts_o.last_probe = (pidx_q == SW'(TABLE_SLOTS - 1));
    sts_o.out_free   = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign occupancy_o = occ_q;

endmodule

// ----- sv/dht_ctrl.sv -----
// ----------------------------------------------------------------------------
// Double hash table controller
// Sequences hashing, probing and the result handoff for one word at a time.
// ----------------------------------------------------------------------------
module dht_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dht_pkg::dp_sts_t sts_i,
  output dht_pkg::dp_cmd_t cmd_o
);
  import dht_pkg::*;

  localparam int unsigned NW = $clog2(HomeNibbles);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_HLOAD = 4'd2;
  localparam logic [3:0] S_HRED  = 4'd3;
  localparam logic [3:0] S_SLOAD = 4'd4;
  localparam logic [3:0] S_SRED  = 4'd5;
  localparam logic [3:0] S_PRIME = 4'd6;
  localparam logic [3:0] S_PROBE = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (sts_i.cmd == CmdNop) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ResMissing;
          state_d        = S_FIN;
        end else if (sts_i.cmd == CmdInsert && sts_i.full) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ResFull;
          state_d        = S_FIN;
        end else begin
          cmd_o.sq_en = 1'b1;
          state_d     = S_HLOAD;
        end
      end
      S_HLOAD: begin
        cmd_o.red_load_home = 1'b1;
        cnt_d               = '0;
        state_d             = S_HRED;
      end
      S_HRED: begin
        cmd_o.red_run = 1'b1;
        cnt_d         = cnt_q + NW'(1);
        if (cnt_q == NW'(HomeNibbles - 1)) begin
          state_d = S_SLOAD;
        end
      end
      S_SLOAD: begin
        cmd_o.red_load_step = 1'b1;
        cnt_d               = '0;
        state_d             = S_SRED;
      end
      S_SRED: begin
        cmd_o.red_run   = 1'b1;
        cmd_o.red_slots = 1'b1;
        cnt_d           = cnt_q + NW'(1);
        if (cnt_q == NW'(StepNibbles - 1)) begin
          state_d = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd_o.probe_prime = 1'b1;
        state_d           = S_PROBE;
      end
      S_PROBE: begin
        // check the slot read last cycle while the next one is fetched
        cmd_o.probe_run = 1'b1;
        if (sts_i.cmd == CmdInsert) begin
          if (!sts_i.rd_used) begin
            cmd_o.wr_ins   = 1'b1;
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ResInserted;
            cmd_o.res_hit  = 1'b1;
            state_d        = S_FIN;
          end else if (sts_i.last_probe) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ResFull;
            state_d        = S_FIN;
          end
        end else begin
          if (sts_i.rd_empty) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ResMissing;
            state_d        = S_FIN;
          end else if (sts_i.rd_used && sts_i.key_match) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_hit = 1'b1;
            if (sts_i.cmd == CmdDelete) begin
              cmd_o.wr_del   = 1'b1;
              cmd_o.res_code = ResDeleted;
            end else begin
              cmd_o.res_code = ResFound;
            end
            state_d = S_FIN;
          end else if (sts_i.last_probe) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ResMissing;
            state_d        = S_FIN;
          end
        end
      end
      S_FIN: begin
        // hold until the output register can take the word
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/double_hash_table_top.sv -----
// ----------------------------------------------------------------------------
// Double hash table top level
// Sequence: home and step hash reductions, then P = 1..TABLE_SLOTS slot
//   probes (one per cycle); no-op and full-table inserts go straight to the result.
// Throughput: one word at a time, set by the nibble-serial modulo reducer
//   and the probe loop; next input accepted in the same cycle as output valid.
// Reset: asynchronous, marks every slot empty and clears the live count.
// ----------------------------------------------------------------------------
module double_hash_table_top #(
  parameter int unsigned TABLE_SLOTS = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [14:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [3:0]  occupancy_o
);
  import dht_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  dht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  dht_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (command_i),
    .key_i       (key_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .slot_o      (slot_o),
    .occupancy_o (occupancy_o)
  );

endmodule

// ----- sv/dht_checker.sv -----
// ----------------------------------------------------------------------------
// Double hash table port checker
// Watches the top level ports and flags sequencing or result slips.
// ----------------------------------------------------------------------------
`include "double_hash_table_top_macros.svh"

module dht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [3:0]  slot_o,
  input logic [3:0]  occupancy_o
);
  import dht_pkg::*;

  logic [10:0] out_word;
  logic        no_hit;

  assign out_word = {status_o, slot_o, occupancy_o};
  assign no_hit   = (status_o == 3'(ResMissing)) || (status_o == 3'(ResFull));

  // a stalled result word holds
  `DHT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word))

  // one word in flight: a taken input closes the input side next cycle
  `DHT_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  // no result can follow an input in the very next cycle
  `DHT_ASSERT_NEXT(a_min_latency, in_valid_i && in_ready_o && !out_valid_o, !out_valid_o)

  // misses and full inserts report slot zero
  `DHT_ASSERT_NOW(a_miss_slot_zero, out_valid_o && no_hit, slot_o == 4'd0)

endmodule

bind double_hash_table_top dht_checker u_dht_checker (.*);
